[design/hdu_pkg.sv]
`timescale 1ns / 1ps

package hdu_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CW                = 33;
    localparam int SQ_STEPS          = 31;
    localparam int SQ_W              = 62;
    localparam int DEG_W             = 31;

    localparam logic signed [31:0] ONE_Q30          = 32'sd1073741824;
    localparam logic signed [31:0] HALF_PI_Q30      = 32'sd1686629713;
    localparam logic signed [31:0] INV_GAIN_Q30     = 32'sd652032874;
    localparam logic signed [31:0] TURN_Q21         = 32'sd754974720;
    localparam logic signed [31:0] HALF_TURN_Q21    = 32'sd377487360;
    localparam logic signed [31:0] QUARTER_TURN_Q21 = 32'sd188743680;
    localparam logic [26:0]        DEG_TO_RAD_Q32   = 27'd74961321;
    localparam logic [25:0]        DIST_MAX         = 26'd67108863;
    localparam logic [15:0]        RADIUS_RESET     = 16'd6371;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314856;
            1: v = 32'd497837829;
            2: v = 32'd263043836;
            3: v = 32'd133525158;
            4: v = 32'd67021686;
            5: v = 32'd33543515;
            6: v = 32'd16775850;
            7: v = 32'd8388437;
            8: v = 32'd4194282;
            9: v = 32'd2097149;
            default: begin
                if (i <= 30) v = 32'((64'd1 << (30 - i)) - 64'd1);
                else v = 32'd0;
            end
        endcase
        return v;
    endfunction

endpackage

[design/hdu_cordic.sv]
`timescale 1ns / 1ps

module hdu_cordic import hdu_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES_DEF,
    parameter bit VECTOR = 1'b0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_tag,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [CW-1:0] i_z,
    output logic                 o_valid,
    output logic                 o_tag,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW-1:0] o_z
);

    logic signed [CW-1:0] r_x [0:STAGES];
    logic signed [CW-1:0] r_y [0:STAGES];
    logic signed [CW-1:0] r_z [0:STAGES];
    logic [STAGES:0]      r_tag;
    logic [STAGES:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_x[0]   <= i_x;
        r_y[0]   <= i_y;
        r_z[0]   <= i_z;
        r_tag[0] <= i_tag;
    end

    genvar i;
    for (i = 0; i < STAGES; i++) begin : g_st
        logic signed [CW-1:0] w_dx, w_dy, w_at;
        logic                 w_sig;
        assign w_dx  = r_y[i] >>> i;
        assign w_dy  = r_x[i] >>> i;
        assign w_at  = signed'({1'b0, atan_q30(i)});
        assign w_sig = VECTOR ? r_y[i][CW-1] : ~r_z[i][CW-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            r_tag[i+1] <= r_tag[i];
            if (w_sig) begin
                r_x[i+1] <= r_x[i] - w_dx;
                r_y[i+1] <= r_y[i] + w_dy;
                r_z[i+1] <= r_z[i] - w_at;
            end else begin
                r_x[i+1] <= r_x[i] + w_dx;
                r_y[i+1] <= r_y[i] - w_dy;
                r_z[i+1] <= r_z[i] + w_at;
            end
        end
    end

    assign o_valid = r_vld[STAGES];
    assign o_tag   = r_tag[STAGES];
    assign o_x     = r_x[STAGES];
    assign o_y     = r_y[STAGES];
    assign o_z     = r_z[STAGES];

endmodule

[design/hdu_isqrt.sv]
`timescale 1ns / 1ps

module hdu_isqrt import hdu_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [SQ_W-1:0] i_value,
    output logic            o_valid,
    output logic [30:0]     o_root
);

    logic [SQ_W-1:0] r_v   [0:SQ_STEPS];
    logic [SQ_W-1:0] r_res [0:SQ_STEPS];
    logic [SQ_STEPS:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_v[0]   <= i_value;
        r_res[0] <= '0;
    end

    genvar j;
    for (j = 0; j < SQ_STEPS; j++) begin : g_st
        localparam int K = SQ_STEPS - 1 - j;
        logic [SQ_W-1:0] w_bit, w_sum;
        logic            w_ge;
        assign w_bit = SQ_W'(1) << (2 * K);
        assign w_sum = r_res[j] + w_bit;
        assign w_ge  = r_v[j] >= w_sum;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else begin
                r_vld[j+1] <= r_vld[j];
            end
            if (w_ge) begin
                r_v[j+1]   <= r_v[j] - w_sum;
                r_res[j+1] <= (r_res[j] >> 1) + w_bit;
            end else begin
                r_v[j+1]   <= r_v[j];
                r_res[j+1] <= r_res[j] >> 1;
            end
        end
    end

    assign o_valid = r_vld[SQ_STEPS];
    assign o_root  = r_res[SQ_STEPS][30:0];

endmodule

[design/haversine_distance_unit.sv]
`timescale 1ns / 1ps
// Channel   Ports                                    Handshake
// input     i_lat_a i_lon_a i_lat_b i_lon_b          i_start while o_busy low
// result    o_distance                               o_valid, one cycle
// config    i_radius_wdata                           i_radius_we
//
// One item enters every cycle; o_busy stays low.
// Between input and result lie two CORDIC pipelines of
// CORDIC_STAGES+1 stages each, a 32-stage square root, and 10 stages of
// reduction, products, clamps and scaling.
// Synchronous reset clears the valid bits and loads radius 6371.
// The receiver cannot stall; results leave on the strobe.

module haversine_distance_unit import hdu_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic signed [27:0] i_lat_a,
    input  logic signed [28:0] i_lon_a,
    input  logic signed [27:0] i_lat_b,
    input  logic signed [28:0] i_lon_b,
    input  logic               i_radius_we,
    input  logic [15:0]        i_radius_wdata,
    output logic               o_valid,
    output logic [25:0]        o_distance
);

    logic [15:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_RESET;
        end else if (i_radius_we) begin
            r_radius <= i_radius_wdata;
        end
    end

    assign o_busy = 1'b0;

    logic                    r_v0, r_v1, r_v2;
    logic signed [DEG_W-1:0] r_deg  [0:3];
    logic signed [31:0]      r_fold [0:3];
    logic [3:0]              r_neg1, r_neg2, r_sgn;
    logic [55:0]             r_prod [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v0 <= i_start;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
        r_deg[0] <= DEG_W'(i_lat_b) - DEG_W'(i_lat_a);
        r_deg[1] <= DEG_W'(i_lon_b) - DEG_W'(i_lon_a);
        r_deg[2] <= DEG_W'(i_lat_a) <<< 1;
        r_deg[3] <= DEG_W'(i_lat_b) <<< 1;
    end

    logic [3:0]          w_cvld, w_ctag;
    logic signed [CW-1:0] w_cx [0:3];
    logic signed [CW-1:0] w_cy [0:3];

    genvar j;
    for (j = 0; j < 4; j++) begin : g_ang
        logic signed [31:0]   w_r0, w_r1, w_r2;
        logic signed [31:0]   n_fold;
        logic                 n_neg;
        logic [28:0]          w_mag;
        logic [CW-1:0]        w_rad;
        logic signed [CW-1:0] w_z;

        assign w_r0 = 32'(r_deg[j]) + HALF_TURN_Q21;
        assign w_r1 = (w_r0 < 0) ? w_r0 + TURN_Q21 :
                      ((w_r0 >= TURN_Q21) ? w_r0 - TURN_Q21 : w_r0);
        assign w_r2 = w_r1 - HALF_TURN_Q21;

        always_comb begin
            n_fold = w_r2;
            n_neg  = 1'b0;
            if (w_r2 > QUARTER_TURN_Q21) begin
                n_fold = HALF_TURN_Q21 - w_r2;
                n_neg  = 1'b1;
            end else if (w_r2 < -QUARTER_TURN_Q21) begin
                n_fold = -HALF_TURN_Q21 - w_r2;
                n_neg  = 1'b1;
            end
        end

        assign w_mag = r_fold[j][31] ? 29'(-r_fold[j]) : 29'(r_fold[j]);
        assign w_rad = CW'((r_prod[j] + 56'd4194304) >> 23);
        assign w_z   = r_sgn[j] ? -signed'(w_rad) : signed'(w_rad);

        always_ff @(posedge i_clk) begin
            r_fold[j] <= n_fold;
            r_neg1[j] <= n_neg;
            r_prod[j] <= 56'(w_mag) * 56'(DEG_TO_RAD_Q32);
            r_sgn[j]  <= r_fold[j][31];
            r_neg2[j] <= r_neg1[j];
        end

        hdu_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b0)) u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_v2),
            .i_tag   (r_neg2[j]),
            .i_x     (CW'(INV_GAIN_Q30)),
            .i_y     ('0),
            .i_z     (w_z),
            .o_valid (w_cvld[j]),
            .o_tag   (w_ctag[j]),
            .o_x     (w_cx[j]),
            .o_y     (w_cy[j]),
            .o_z     ()
        );
    end

    function automatic logic signed [31:0] clamp_one(input logic signed [CW-1:0] v);
        logic signed [31:0] r;
        if (v > CW'(ONE_Q30)) r = ONE_Q30;
        else if (v < -CW'(ONE_Q30)) r = -ONE_Q30;
        else r = 32'(v);
        return r;
    endfunction

    logic               r_vs, r_vp1, r_vp2, r_va;
    logic signed [31:0] r_s1, r_s2, r_c1, r_c2;
    logic signed [31:0] r_s1sq, r_s2sq, r_cc, r_s1sq2, r_t;
    logic signed [63:0] w_p1, w_p2, w_p3, w_p4;
    logic signed [32:0] w_sum;
    logic [30:0]        r_a, r_b;

    assign w_p1  = 64'(r_s1) * 64'(r_s1);
    assign w_p2  = 64'(r_s2) * 64'(r_s2);
    assign w_p3  = 64'(r_c1) * 64'(r_c2);
    assign w_p4  = 64'(r_cc) * 64'(r_s2sq);
    assign w_sum = 33'(r_s1sq2) + 33'(r_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs  <= 1'b0;
            r_vp1 <= 1'b0;
            r_vp2 <= 1'b0;
            r_va  <= 1'b0;
        end else begin
            r_vs  <= w_cvld[0];
            r_vp1 <= r_vs;
            r_vp2 <= r_vp1;
            r_va  <= r_vp2;
        end
        r_s1    <= clamp_one(w_cy[0]);
        r_s2    <= clamp_one(w_cy[1]);
        r_c1    <= w_ctag[2] ? -clamp_one(w_cx[2]) : clamp_one(w_cx[2]);
        r_c2    <= w_ctag[3] ? -clamp_one(w_cx[3]) : clamp_one(w_cx[3]);
        r_s1sq  <= 32'(w_p1 >>> 30);
        r_s2sq  <= 32'(w_p2 >>> 30);
        r_cc    <= 32'(w_p3 >>> 30);
        r_s1sq2 <= r_s1sq;
        r_t     <= 32'(w_p4 >>> 30);
        if (w_sum < 0) begin
            r_a <= '0;
            r_b <= 31'(ONE_Q30);
        end else if (w_sum > 33'(ONE_Q30)) begin
            r_a <= 31'(ONE_Q30);
            r_b <= '0;
        end else begin
            r_a <= 31'(w_sum);
            r_b <= 31'(33'(ONE_Q30) - w_sum);
        end
    end

    logic        w_qa_vld, w_qb_vld;
    logic [30:0] w_root_a, w_root_b;

    hdu_isqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_value ({1'b0, r_a, 30'd0}),
        .o_valid (w_qa_vld),
        .o_root  (w_root_a)
    );

    hdu_isqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_va),
        .i_value ({1'b0, r_b, 30'd0}),
        .o_valid (w_qb_vld),
        .o_root  (w_root_b)
    );

    logic                 w_vvld;
    logic signed [CW-1:0] w_vz;

    hdu_cordic #(.STAGES(CORDIC_STAGES), .VECTOR(1'b1)) u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_qa_vld & w_qb_vld),
        .i_tag   (1'b0),
        .i_x     (CW'(w_root_b)),
        .i_y     (CW'(w_root_a)),
        .i_z     ('0),
        .o_valid (w_vvld),
        .o_tag   (),
        .o_x     (),
        .o_y     (),
        .o_z     (w_vz)
    );

    logic        r_vang, r_vm;
    logic [30:0] r_ang;
    logic [46:0] r_dprod;
    logic [26:0] w_dist;

    assign w_dist = 27'((r_dprod + 47'd1048576) >> 21);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vang  <= 1'b0;
            r_vm    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            r_vang  <= w_vvld;
            r_vm    <= r_vang;
            o_valid <= r_vm;
        end
        if (w_vz < 0) r_ang <= '0;
        else if (w_vz > CW'(HALF_PI_Q30)) r_ang <= 31'(HALF_PI_Q30);
        else r_ang <= 31'(w_vz);
        r_dprod    <= 47'(r_radius) * 47'(r_ang);
        o_distance <= (w_dist > 27'(DIST_MAX)) ? DIST_MAX : 26'(w_dist);
    end

endmodule

[tb/tb_haversine_distance_unit.sv]
`timescale 1ns / 1ps

module tb_haversine_distance_unit;
    import hdu_pkg::*;

    typedef struct packed {
        logic signed [27:0] lat_a;
        logic signed [28:0] lon_a;
        logic signed [27:0] lat_b;
        logic signed [28:0] lon_b;
    } t_coord_pair;

    localparam int  LATENCY       = 2 * CORDIC_STAGES_DEF + 44;
    localparam int  STALL_LIMIT   = 20000;
    localparam int  RANDOM_ITEMS  = 250;
    localparam longint Q30_ONE    = 64'sd1073741824;
    localparam longint Q30_HALFPI = 64'sd1686629713;
    localparam longint GAIN_INV   = 64'sd652032874;
    localparam longint RAD_SCALE  = 64'sd74961321;
    localparam longint FULL_TURN  = 64'sd754974720;
    localparam longint HALF_TURN  = 64'sd377487360;
    localparam longint QTR_TURN   = 64'sd188743680;
    localparam longint LAT_LIM    = 94371840;
    localparam longint LON_LIM    = 188743680;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic signed [27:0] i_lat_a;
    logic signed [28:0] i_lon_a;
    logic signed [27:0] i_lat_b;
    logic signed [28:0] i_lon_b;
    logic               i_radius_we;
    logic [15:0]        i_radius_wdata;
    logic               o_valid;
    logic [25:0]        o_distance;

    t_coord_pair  pending_items[$];
    logic [25:0]  expected_dist[$];
    logic [15:0]  radius_km;
    int           sender_idle_pct;
    int           mismatches;
    int           sent_cnt;
    int           taken_cnt;
    int           stall_cycles;

    haversine_distance_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_lat_a       (i_lat_a),
        .i_lon_a       (i_lon_a),
        .i_lat_b       (i_lat_b),
        .i_lon_b       (i_lon_b),
        .i_radius_we   (i_radius_we),
        .i_radius_wdata(i_radius_wdata),
        .o_valid       (o_valid),
        .o_distance    (o_distance)
    );

    function automatic longint arctan_step(input int i);
        longint tbl[10] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149};
        if (i < 10) return tbl[i];
        if (i <= 30) return (64'sd1 <<< (30 - i)) - 1;
        return 0;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void rotate_sin_cos(input longint deg, output longint s,
                                           output longint c);
        longint r, rad, x, y, z, dx, dy;
        longint unsigned mag;
        logic flip;
        r = (deg + HALF_TURN) % FULL_TURN;
        if (r < 0) r += FULL_TURN;
        r -= HALF_TURN;
        flip = 1'b0;
        if (r > QTR_TURN) begin
            r = HALF_TURN - r;
            flip = 1'b1;
        end else if (r < -QTR_TURN) begin
            r = -HALF_TURN - r;
            flip = 1'b1;
        end
        mag = r < 0 ? -r : r;
        rad = longint'((mag * RAD_SCALE + (64'd1 << 22)) >> 23);
        z = r < 0 ? -rad : rad;
        x = GAIN_INV;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= arctan_step(i);
            end else begin
                x += dx; y -= dy; z += arctan_step(i);
            end
        end
        s = clip(y, -Q30_ONE, Q30_ONE);
        x = clip(x, -Q30_ONE, Q30_ONE);
        c = flip ? -x : x;
    endfunction

    function automatic longint int_root(input longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        for (int k = 30; k >= 0; k--) begin
            bitv = 64'd1 << (2 * k);
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += arctan_step(i);
            end else begin
                x -= dx; y += dy; z -= arctan_step(i);
            end
        end
        return clip(z, 0, Q30_HALFPI);
    endfunction

    function automatic logic [25:0] great_circle(input t_coord_pair p, input logic [15:0] rad_km);
        longint la, oa, lb, ob, s1, s2, c1, c2, junk, hav, ang;
        longint unsigned d;
        la = p.lat_a;
        oa = p.lon_a;
        lb = p.lat_b;
        ob = p.lon_b;
        rotate_sin_cos(lb - la, s1, junk);
        rotate_sin_cos(ob - oa, s2, junk);
        rotate_sin_cos(2 * la, junk, c1);
        rotate_sin_cos(2 * lb, junk, c2);
        hav = clip(((s1 * s1) >>> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >>> 30)) >>> 30),
                   0, Q30_ONE);
        ang = vector_angle(int_root(longint'(Q30_ONE - hav) << 30),
                           int_root(longint'(hav) << 30));
        d = (longint'(rad_km) * (2 * ang) + (64'd1 << 21)) >> 22;
        if (d > 64'd67108863) d = 64'd67108863;
        return d[25:0];
    endfunction

    function automatic t_coord_pair make_pair(input longint la, input longint oa,
                                              input longint lb, input longint ob);
        t_coord_pair p;
        p.lat_a = la[27:0];
        p.lon_a = oa[28:0];
        p.lat_b = lb[27:0];
        p.lon_b = ob[28:0];
        return p;
    endfunction

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(32'(2 * lim))) - lim;
    endfunction

    function automatic t_coord_pair random_pair();
        t_coord_pair p;
        longint la, oa;
        case ($urandom_range(9))
            0, 1: begin
                p.lat_a = 28'($urandom); p.lon_a = 29'($urandom);
                p.lat_b = 28'($urandom); p.lon_b = 29'($urandom);
            end
            2, 3: begin
                la = rand_span(LAT_LIM);
                oa = rand_span(LON_LIM);
                p = make_pair(la, oa, clip(la + longint'($urandom_range(4095)) - 2048,
                              -LAT_LIM, LAT_LIM), oa + longint'($urandom_range(8191)) - 4096);
            end
            4: begin
                la = rand_span(LAT_LIM);
                oa = rand_span(LON_LIM);
                p = make_pair(la, oa, -la, oa > 0 ? oa - LON_LIM : oa + LON_LIM);
            end
            default: p = make_pair(rand_span(LAT_LIM), rand_span(LON_LIM),
                                   rand_span(LAT_LIM), rand_span(LON_LIM));
        endcase
        return p;
    endfunction

    task automatic drain_and_set(input logic [15:0] value);
        while (pending_items.size() != 0 || expected_dist.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        @(negedge i_clk);
        i_radius_we    <= 1'b1;
        i_radius_wdata <= value;
        radius_km      = value;
        @(negedge i_clk);
        i_radius_we    <= 1'b0;
    endtask

    task automatic queue_random(input int count);
        for (int n = 0; n < count; n++) pending_items.push_back(random_pair());
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // hold the current item until the DUT takes it
    always @(negedge i_clk) begin
        if (!(i_start && taken_cnt != sent_cnt)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                t_coord_pair p;
                p = pending_items.pop_front();
                i_lat_a <= p.lat_a;
                i_lon_a <= p.lon_a;
                i_lat_b <= p.lat_b;
                i_lon_b <= p.lon_b;
                i_start <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) begin
            taken_cnt <= taken_cnt + 1;
            expected_dist.push_back(great_circle({i_lat_a, i_lon_a, i_lat_b, i_lon_b},
                                                 radius_km));
        end
        if (i_rst_n && o_valid) begin
            if (expected_dist.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected distance %0d", o_distance);
            end else begin
                logic [25:0] want;
                want = expected_dist.pop_front();
                if (want !== o_distance) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("distance mismatch: expected %0d actual %0d", want, o_distance);
                end
            end
        end
        if ((i_start && !o_busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_haversine_distance_unit: FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_lat_a        = '0;
        i_lon_a        = '0;
        i_lat_b        = '0;
        i_lon_b        = '0;
        i_radius_we    = 1'b0;
        i_radius_wdata = '0;
        radius_km      = 16'd6371;
        sender_idle_pct = 36;
        mismatches     = 0;
        sent_cnt       = 0;
        taken_cnt      = 0;
        stall_cycles   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        pending_items.push_back(make_pair(0, 0, 0, 0));
        pending_items.push_back(make_pair(LAT_LIM, 0, -LAT_LIM, 0));
        pending_items.push_back(make_pair(0, -LON_LIM, 0, LON_LIM));
        pending_items.push_back(make_pair(0, 0, 0, LON_LIM));
        pending_items.push_back(make_pair(LAT_LIM, LON_LIM, LAT_LIM, -LON_LIM));
        pending_items.push_back(make_pair(-LAT_LIM, 0, -LAT_LIM, LON_LIM));
        pending_items.push_back(make_pair(-134217728, -268435456, 134217727, 268435455));
        pending_items.push_back(make_pair(134217727, 268435455, -134217728, -268435456));
        pending_items.push_back(make_pair(134217727, 268435455, 134217727, 268435455));
        pending_items.push_back(make_pair(LAT_LIM / 2, 100, LAT_LIM / 2, 101));
        pending_items.push_back(make_pair(0, 0, 1, 0));
        pending_items.push_back(make_pair(0, 0, 0, -1));
        pending_items.push_back(make_pair(LAT_LIM / 3, LON_LIM / 2,
                                          -LAT_LIM / 3, -LON_LIM / 2));
        pending_items.push_back(make_pair(2 * LAT_LIM, 0, 0, 3 * LON_LIM));
        pending_items.push_back(make_pair(0, 0, LAT_LIM, 0));
        queue_random(RANDOM_ITEMS);

        drain_and_set(16'd1);
        sender_idle_pct = 70;
        pending_items.push_back(make_pair(LAT_LIM, 0, -LAT_LIM, 0));
        queue_random(RANDOM_ITEMS);

        drain_and_set(16'd65535);
        pending_items.push_back(make_pair(LAT_LIM, 0, -LAT_LIM, 0));
        pending_items.push_back(make_pair(0, -LON_LIM, 0, LON_LIM));
        queue_random(RANDOM_ITEMS);

        drain_and_set(16'($urandom_range(65535, 1)));
        sender_idle_pct = 0;
        queue_random(RANDOM_ITEMS);

        drain_and_set(16'd6371);
        queue_random(RANDOM_ITEMS);

        while (pending_items.size() != 0 || expected_dist.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_haversine_distance_unit: PASS");
        end else begin
            $display("tb_haversine_distance_unit: FAIL");
        end
        $finish;
    end

endmodule

[haversine_distance_unit.f]
design/hdu_pkg.sv
design/hdu_cordic.sv
design/hdu_isqrt.sv
design/haversine_distance_unit.sv
tb/tb_haversine_distance_unit.sv
